// File: rtl/crt_pkg.sv
// Shared types, status codes and defaults for the codepoint range table.
package crt_pkg;

	localparam int MAX_RUNS_DEF     = 64;
	localparam int MAX_GLYPHS_DEF   = 1024;
	localparam int PAYLOAD_BITS_DEF = 16;
	localparam int CP_W             = 21;

	localparam logic [2:0] ST_NEW     = 3'd0;
	localparam logic [2:0] ST_PREPEND = 3'd1;
	localparam logic [2:0] ST_APPEND  = 3'd2;
	localparam logic [2:0] ST_MERGE   = 3'd3;
	localparam logic [2:0] ST_DUP     = 3'd4;
	localparam logic [2:0] ST_FULL    = 3'd5;
	localparam logic [2:0] ST_FOUND   = 3'd6;
	localparam logic [2:0] ST_MISS    = 3'd7;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef struct packed {
		logic            operation;
		logic [CP_W-1:0] codepoint;
		logic [15:0]     payload;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] found_payload;
		logic [6:0]  run_count;
	} out_t;

endpackage

// File: rtl/crt_ram.sv
// Generic simple dual-port RAM with registered read.
module crt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/codepoint_range_table_top.sv
// Sorted codepoint run table with packed per-codepoint payload store.
//
// Usage: drive cmd and raise start; the transaction is taken at a clock edge
// where start is high and busy is low. Each transaction yields exactly one
// result on the result port, flagged by done for a single cycle; the receiver
// cannot stall it. A new command may be taken in the cycle done is high.
// Steps per transaction (R = runs held, G = payloads held):
//   lookup: each run is read and checked until the hit, then the payload is read.
//   insert: each run is read and checked, then each payload above the insert point
//   is moved up (up to G), then each run above it is moved when a run is opened
//   or two runs merge (up to R), plus bookkeeping states.
// The scan and both shifts go through the single read port of each RAM, one
// entry at a time. Duplicate and full inserts end after the scan.
// Reset clears the state, the done strobe and the run and payload counts; RAM
// contents are never read before being written, so no clearing pass is needed.
module codepoint_range_table_top #(
	parameter int MAX_RUNS     = crt_pkg::MAX_RUNS_DEF,
	parameter int MAX_GLYPHS   = crt_pkg::MAX_GLYPHS_DEF,
	parameter int PAYLOAD_BITS = crt_pkg::PAYLOAD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  crt_pkg::in_t  cmd,
	output logic          done,
	output crt_pkg::out_t result
);
	import crt_pkg::*;

	localparam int RAW = $clog2(MAX_RUNS);
	localparam int RCW = $clog2(MAX_RUNS + 1);
	localparam int GAW = $clog2(MAX_GLYPHS);
	localparam int GCW = $clog2(MAX_GLYPHS + 1);
	localparam int RW  = CP_W + GCW;

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_RD   = 13'b0000000000010,
		S_CHK  = 13'b0000000000100,
		S_EXEC = 13'b0000000001000,
		S_GRD  = 13'b0000000010000,
		S_GWR  = 13'b0000000100000,
		S_GPUT = 13'b0000001000000,
		S_NRD  = 13'b0000010000000,
		S_NCHK = 13'b0000100000000,
		S_RRD  = 13'b0001000000000,
		S_RWR  = 13'b0010000000000,
		S_RPUT = 13'b0100000000000,
		S_LKW  = 13'b1000000000000
	} state_t;

	state_t           state_q;
	in_t              req_q;
	logic [RCW-1:0]   runs_q, idx_q, k_q;
	logic [GCW-1:0]   glyphs_q, off_q, pos_q, j_q;
	logic [2:0]       kind_q;
	logic [CP_W-1:0]  s_q;
	logic [GCW-1:0]   l_q;
	logic             dn_q;
	logic             done_q;
	out_t             res_q;

	logic             run_we, gly_we;
	logic [RAW-1:0]   run_waddr, run_raddr;
	logic [RW-1:0]    run_wdata, run_rdata;
	logic [GAW-1:0]   gly_waddr, gly_raddr;
	logic [PAYLOAD_BITS-1:0] gly_wdata, gly_rdata;

	crt_ram #(.WIDTH(RW), .DEPTH(MAX_RUNS)) u_runs (
		.clk(clk), .we(run_we), .waddr(run_waddr), .wdata(run_wdata),
		.raddr(run_raddr), .rdata(run_rdata)
	);

	crt_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(MAX_GLYPHS)) u_glyphs (
		.clk(clk), .we(gly_we), .waddr(gly_waddr), .wdata(gly_wdata),
		.raddr(gly_raddr), .rdata(gly_rdata)
	);

	// Fields of the run entry just read, and scan compares on 22 bits.
	logic [CP_W-1:0] rd_s;
	logic [GCW-1:0]  rd_l;
	logic [CP_W:0]   cp22, s22, l22, diff22;
	logic            hit_lo, below, in_run, at_end, last;

	assign rd_s   = run_rdata[RW-1:GCW];
	assign rd_l   = run_rdata[GCW-1:0];
	assign cp22   = {1'b0, req_q.codepoint};
	assign s22    = {1'b0, rd_s};
	assign l22    = (CP_W + 1)'(rd_l);
	assign diff22 = cp22 - s22;
	assign hit_lo = (cp22 + 1'b1) == s22;
	assign below  = cp22 < s22;
	assign in_run = (cp22 >= s22) && (diff22 < l22);
	assign at_end = cp22 == (s22 + l22);
	assign last   = (idx_q + 1'b1) == runs_q;

	always_comb begin
		run_we    = 1'b0;
		run_waddr = idx_q[RAW-1:0];
		run_wdata = {s_q, l_q + 1'b1};
		run_raddr = idx_q[RAW-1:0];
		gly_we    = 1'b0;
		gly_waddr = pos_q[GAW-1:0];
		gly_wdata = PAYLOAD_BITS'(req_q.payload);
		gly_raddr = GAW'(off_q + GCW'(diff22));
		unique case (state_q)
			S_GRD: begin
				gly_raddr = GAW'(j_q - 1'b1);
			end
			S_GWR: begin
				gly_we    = 1'b1;
				gly_waddr = j_q[GAW-1:0];
				gly_wdata = gly_rdata;
			end
			S_GPUT: begin
				gly_we = 1'b1;
				if (kind_q == ST_PREPEND) begin
					run_we    = 1'b1;
					run_wdata = {s_q - 1'b1, l_q + 1'b1};
				end else if (kind_q == ST_APPEND && !((idx_q + 1'b1) < runs_q)) begin
					run_we = 1'b1;
				end
			end
			S_NRD: begin
				run_raddr = RAW'(idx_q + 1'b1);
			end
			S_NCHK: begin
				run_we = 1'b1;
				if (hit_lo) begin
					run_wdata = {s_q, l_q + 1'b1 + rd_l};
				end
			end
			S_RRD: begin
				run_raddr = dn_q ? RAW'(k_q + 1'b1) : RAW'(k_q - 1'b1);
			end
			S_RWR: begin
				run_we    = 1'b1;
				run_waddr = k_q[RAW-1:0];
				run_wdata = run_rdata;
			end
			S_RPUT: begin
				run_we    = 1'b1;
				run_wdata = {req_q.codepoint, GCW'(1)};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			runs_q   <= '0;
			glyphs_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= cmd;
						idx_q <= '0;
						off_q <= '0;
						if (runs_q != '0) begin
							state_q <= S_RD;
						end else if (cmd.operation == OP_LOOKUP) begin
							done_q    <= 1'b1;
							res_q     <= '{ST_MISS, 16'd0, 7'(runs_q)};
						end else begin
							kind_q  <= ST_NEW;
							pos_q   <= '0;
							state_q <= S_EXEC;
						end
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					s_q <= rd_s;
					l_q <= rd_l;
					if (req_q.operation == OP_LOOKUP) begin
						if (in_run) begin
							state_q <= S_LKW;
						end else if (last) begin
							done_q  <= 1'b1;
							res_q   <= '{ST_MISS, 16'd0, 7'(runs_q)};
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							off_q   <= off_q + rd_l;
							state_q <= S_RD;
						end
					end else begin
						priority if (hit_lo) begin
							kind_q  <= ST_PREPEND;
							pos_q   <= off_q;
							state_q <= S_EXEC;
						end else if (below) begin
							kind_q  <= ST_NEW;
							pos_q   <= off_q;
							state_q <= S_EXEC;
						end else if (in_run) begin
							done_q  <= 1'b1;
							res_q   <= '{ST_DUP, 16'd0, 7'(runs_q)};
							state_q <= S_IDLE;
						end else if (at_end) begin
							kind_q  <= ST_APPEND;
							pos_q   <= off_q + rd_l;
							state_q <= S_EXEC;
						end else if (last) begin
							kind_q  <= ST_NEW;
							pos_q   <= off_q + rd_l;
							idx_q   <= idx_q + 1'b1;
							state_q <= S_EXEC;
						end else begin
							idx_q   <= idx_q + 1'b1;
							off_q   <= off_q + rd_l;
							state_q <= S_RD;
						end
					end
				end
				S_EXEC: begin
					if (glyphs_q >= GCW'(MAX_GLYPHS) ||
					    (kind_q == ST_NEW && runs_q >= RCW'(MAX_RUNS))) begin
						done_q  <= 1'b1;
						res_q   <= '{ST_FULL, 16'd0, 7'(runs_q)};
						state_q <= S_IDLE;
					end else begin
						j_q     <= glyphs_q;
						state_q <= (glyphs_q == pos_q) ? S_GPUT : S_GRD;
					end
				end
				S_GRD: begin
					state_q <= S_GWR;
				end
				S_GWR: begin
					j_q     <= j_q - 1'b1;
					state_q <= ((j_q - 1'b1) == pos_q) ? S_GPUT : S_GRD;
				end
				S_GPUT: begin
					glyphs_q <= glyphs_q + 1'b1;
					if (kind_q == ST_PREPEND) begin
						done_q  <= 1'b1;
						res_q   <= '{ST_PREPEND, 16'd0, 7'(runs_q)};
						state_q <= S_IDLE;
					end else if (kind_q == ST_APPEND) begin
						if ((idx_q + 1'b1) < runs_q) begin
							state_q <= S_NRD;
						end else begin
							done_q  <= 1'b1;
							res_q   <= '{ST_APPEND, 16'd0, 7'(runs_q)};
							state_q <= S_IDLE;
						end
					end else begin
						k_q     <= runs_q;
						dn_q    <= 1'b0;
						state_q <= (runs_q == idx_q) ? S_RPUT : S_RRD;
					end
				end
				S_NRD: begin
					state_q <= S_NCHK;
				end
				S_NCHK: begin
					if (hit_lo) begin
						k_q  <= idx_q + 1'b1;
						dn_q <= 1'b1;
						if ((idx_q + 2'd2) < runs_q) begin
							state_q <= S_RRD;
						end else begin
							runs_q  <= runs_q - 1'b1;
							done_q  <= 1'b1;
							res_q   <= '{ST_MERGE, 16'd0, 7'(runs_q - 1'b1)};
							state_q <= S_IDLE;
						end
					end else begin
						done_q  <= 1'b1;
						res_q   <= '{ST_APPEND, 16'd0, 7'(runs_q)};
						state_q <= S_IDLE;
					end
				end
				S_RRD: begin
					state_q <= S_RWR;
				end
				S_RWR: begin
					if (dn_q) begin
						k_q <= k_q + 1'b1;
						if ((k_q + 2'd2) == runs_q) begin
							runs_q  <= runs_q - 1'b1;
							done_q  <= 1'b1;
							res_q   <= '{ST_MERGE, 16'd0, 7'(runs_q - 1'b1)};
							state_q <= S_IDLE;
						end else begin
							state_q <= S_RRD;
						end
					end else begin
						k_q     <= k_q - 1'b1;
						state_q <= ((k_q - 1'b1) == idx_q) ? S_RPUT : S_RRD;
					end
				end
				S_RPUT: begin
					runs_q  <= runs_q + 1'b1;
					done_q  <= 1'b1;
					res_q   <= '{ST_NEW, 16'd0, 7'(runs_q + 1'b1)};
					state_q <= S_IDLE;
				end
				S_LKW: begin
					done_q  <= 1'b1;
					res_q   <= '{ST_FOUND, 16'(gly_rdata), 7'(runs_q)};
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted transaction vanished");

	a_runs_bound: assert property (@(posedge clk) disable iff (!arst_n)
		runs_q <= RCW'(MAX_RUNS))
		else $error("run count above capacity");

	a_glyph_bound: assert property (@(posedge clk) disable iff (!arst_n)
		glyphs_q <= GCW'(MAX_GLYPHS))
		else $error("payload count above capacity");

endmodule

// File: bench/codepoint_range_table_top_test.sv
// Self-checking testbench for the codepoint range table: directed and random inserts/lookups.
`timescale 1ns / 1ps

module codepoint_range_table_top_test;
	import crt_pkg::*;

	localparam int RUNS_MAX   = MAX_RUNS_DEF;
	localparam int GLYPHS_MAX = MAX_GLYPHS_DEF;
	localparam longint CYCLE_LIMIT = 64'd12000000;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	in_t   cmd;
	logic  done;
	out_t  result;

	codepoint_range_table_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .result(result)
	);

	// shadow copy of the table
	logic [20:0] tbl_start [RUNS_MAX];
	int          tbl_len   [RUNS_MAX];
	int          tbl_runs;
	logic [15:0] tbl_glyph [GLYPHS_MAX];
	int          tbl_glyphs;

	out_t        expected_results [$];
	int          fail_count;
	longint      cycle_count;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[codepoint_range_table_top] ERROR");
			$finish;
		end
	end

	function automatic out_t table_apply(in_t t);
		out_t r;
		int   off, at, pos, k;
		logic [2:0] kind;
		logic decided;
		r = '0;
		off = 0;
		if (t.operation == OP_LOOKUP) begin
			r.status = ST_MISS;
			for (int i = 0; i < tbl_runs; i++) begin
				if (t.codepoint >= tbl_start[i] && int'(t.codepoint - tbl_start[i]) < tbl_len[i]) begin
					r.status = ST_FOUND;
					r.found_payload = tbl_glyph[off + int'(t.codepoint - tbl_start[i])];
					break;
				end
				off += tbl_len[i];
			end
			r.run_count = tbl_runs[6:0];
			return r;
		end
		kind = ST_NEW;
		pos = 0;
		at = tbl_runs;
		decided = 1'b0;
		for (int i = 0; i < tbl_runs; i++) begin
			if ({1'b0, t.codepoint} + 22'd1 == {1'b0, tbl_start[i]}) begin
				kind = ST_PREPEND; pos = off; at = i; decided = 1'b1; break;
			end
			if (t.codepoint < tbl_start[i]) begin
				kind = ST_NEW; pos = off; at = i; decided = 1'b1; break;
			end
			if (int'(t.codepoint - tbl_start[i]) < tbl_len[i]) begin
				kind = ST_DUP; decided = 1'b1; break;
			end
			if (int'(t.codepoint) == int'(tbl_start[i]) + tbl_len[i]) begin
				kind = ST_APPEND; pos = off + tbl_len[i]; at = i; decided = 1'b1; break;
			end
			off += tbl_len[i];
		end
		if (!decided) pos = off;
		if (kind == ST_DUP) r.status = ST_DUP;
		else if (tbl_glyphs >= GLYPHS_MAX || (kind == ST_NEW && tbl_runs >= RUNS_MAX))
			r.status = ST_FULL;
		else begin
			for (k = tbl_glyphs; k > pos; k--) tbl_glyph[k] = tbl_glyph[k-1];
			tbl_glyph[pos] = t.payload;
			tbl_glyphs++;
			r.status = kind;
			if (kind == ST_PREPEND) begin
				tbl_start[at] = tbl_start[at] - 21'd1;
				tbl_len[at]++;
			end else if (kind == ST_APPEND) begin
				tbl_len[at]++;
				if (at + 1 < tbl_runs && int'(t.codepoint) + 1 == int'(tbl_start[at+1])) begin
					tbl_len[at] += tbl_len[at+1];
					for (k = at + 1; k < tbl_runs - 1; k++) begin
						tbl_start[k] = tbl_start[k+1];
						tbl_len[k] = tbl_len[k+1];
					end
					tbl_runs--;
					r.status = ST_MERGE;
				end
			end else begin
				for (k = tbl_runs; k > at; k--) begin
					tbl_start[k] = tbl_start[k-1];
					tbl_len[k] = tbl_len[k-1];
				end
				tbl_start[at] = t.codepoint;
				tbl_len[at] = 1;
				tbl_runs++;
			end
		end
		r.run_count = tbl_runs[6:0];
		return r;
	endfunction

	always @(posedge clk) begin
		out_t want;
		if (done) begin
			if (expected_results.size() == 0) begin
				$error("result with no transaction pending: %p", result);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, result.status);
					fail_count++;
				end
				if (result.found_payload !== want.found_payload) begin
					$error("found_payload: expected %0h, actual %0h",
						want.found_payload, result.found_payload);
					fail_count++;
				end
				if (result.run_count !== want.run_count) begin
					$error("run_count: expected %0d, actual %0d", want.run_count, result.run_count);
					fail_count++;
				end
			end
		end
	end

	// start stays high after acceptance when the next transaction follows at once
	task automatic send_item(logic op, logic [20:0] cp, logic [15:0] pl, bit no_gap = 1'b0);
		in_t t;
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		t.operation = op;
		t.codepoint = cp;
		t.payload = pl;
		start <= 1'b1;
		cmd <= t;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_results.push_back(table_apply(t));
	endtask

	task automatic send_rand_gap(logic op, logic [20:0] cp, logic [15:0] pl);
		send_item(op, cp, pl, ($urandom_range(0, 3) == 0));
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		start <= 1'b0;
		while (expected_results.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic test_directed();
		send_item(OP_LOOKUP, 21'd0, 16'hFFFF);
		send_item(OP_INSERT, 21'd0, 16'hFFFF);
		send_item(OP_INSERT, 21'd0, 16'h1234);
		send_item(OP_INSERT, 21'd2, 16'h0002);
		send_item(OP_INSERT, 21'd1, 16'h0001);
		send_item(OP_INSERT, 21'h1FFFFF, 16'hAAAA);
		send_item(OP_INSERT, 21'h1FFFFE, 16'h5555);
		send_item(OP_INSERT, 21'h10FFFF, 16'h0000);
		send_item(OP_INSERT, 21'h110000, 16'h8001);
		send_item(OP_INSERT, 21'd100, 16'h0100);
		send_item(OP_INSERT, 21'd99, 16'h0099);
		send_item(OP_INSERT, 21'd101, 16'h0101);
		send_item(OP_LOOKUP, 21'd1, 16'h0);
		send_item(OP_LOOKUP, 21'd99, 16'h0);
		send_item(OP_LOOKUP, 21'h1FFFFF, 16'h0);
		send_item(OP_LOOKUP, 21'h1FFFFD, 16'h0);
		send_item(OP_LOOKUP, 21'd50, 16'h0);
		send_item(OP_INSERT, 21'd100, 16'h7777);
	endtask

	// dense inserts in a narrow window build long runs and merges
	task automatic test_random_window(int count, int base, int span);
		int roll;
		logic [20:0] cp;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 5) cp = 21'($urandom);
			else cp = 21'(base + $urandom_range(0, span - 1));
			send_rand_gap(roll >= 60 ? OP_LOOKUP : OP_INSERT, cp, 16'($urandom));
		end
	endtask

	// push to the run limit with scattered points, then try contiguous inserts toward the glyph limit
	task automatic test_fill();
		for (int i = 0; i < 90; i++)
			send_rand_gap(OP_INSERT, 21'(3000 + 4 * $urandom_range(0, 120)), 16'($urandom));
		for (int i = 0; i < 1100 && tbl_glyphs < GLYPHS_MAX; i++)
			send_item(OP_INSERT, 21'(20000 + i), 16'($urandom), 1'b1);
		for (int i = 0; i < 20; i++)
			send_rand_gap(1'($urandom_range(0, 1)), 21'($urandom_range(2990, 3500)),
				16'($urandom));
	endtask

	initial begin
		fail_count = 0;
		cycle_count = 0;
		tbl_runs = 0;
		tbl_glyphs = 0;
		start = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_window(800, 500, 200);
		test_random_window(150, 21'h1FFF80, 128);
		test_fill();
		drain();
		if (fail_count == 0 && expected_results.size() == 0)
			$display("[codepoint_range_table_top] OK");
		else
			$display("[codepoint_range_table_top] ERROR");
		$finish;
	end

endmodule

// File: codepoint_range_table_top.f
rtl/crt_pkg.sv
rtl/crt_ram.sv
rtl/codepoint_range_table_top.sv
bench/codepoint_range_table_top_test.sv
